FILE: design/archive_byte_descrambler_assert.svh
// Assertion macros for the descrambler. Empty under synthesis.
`ifndef ARCHIVE_BYTE_DESCRAMBLER_ASSERT_SVH
`define ARCHIVE_BYTE_DESCRAMBLER_ASSERT_SVH

`ifndef SYNTHESIS

// Condition must hold at every edge out of reset
`define ABD_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("descrambler check failed");

// Trigger in one cycle implies a consequence in the next
`define ABD_ASSERT_NEXT(label, clk, rst_n, trig, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error("descrambler sequence check failed");

`else

`define ABD_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define ABD_ASSERT_NEXT(label, clk, rst_n, trig, cons)

`endif

`endif

FILE: design/abd_pkg.sv
package abd_pkg;

  // Register indexes
  localparam logic CFG_BYPASS_PLAIN = 1'b0;
  localparam logic CFG_START_OFFSET = 1'b1;

  // Mode codes
  localparam logic [1:0] MODE_PASS = 2'd0;
  localparam logic [1:0] MODE_A    = 2'd1;
  localparam logic [1:0] MODE_B    = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } abd_in_t;

  typedef struct packed {
    logic [7:0] plain_byte;
    logic       last_out;
  } abd_out_t;

  // XOR key table, ten entries
  function automatic logic [7:0] xor_key(input logic [3:0] idx);
    logic [7:0] k;
    case (idx)
      4'd0:    k = 8'hff;
      4'd1:    k = 8'hff;
      4'd2:    k = 8'hff;
      4'd3:    k = 8'h01;
      4'd4:    k = 8'h9c;
      4'd5:    k = 8'haa;
      4'd6:    k = 8'ha5;
      4'd7:    k = 8'h00;
      4'd8:    k = 8'h30;
      4'd9:    k = 8'hff;
      default: k = 8'h00;
    endcase
    return k;
  endfunction

  // Quotient of a residue mod 25 by 5
  function automatic logic [2:0] div5(input logic [4:0] p);
    logic [2:0] q;
    if (p >= 5'd20)      q = 3'd4;
    else if (p >= 5'd15) q = 3'd3;
    else if (p >= 5'd10) q = 3'd2;
    else if (p >= 5'd5)  q = 3'd1;
    else                 q = 3'd0;
    return q;
  endfunction

  // 32-bit value mod 3: 16 == 1 (mod 3), so fold nibbles
  function automatic logic [1:0] mod3_32(input logic [31:0] x);
    logic [6:0] s;
    logic [4:0] s2;
    logic [3:0] s3;
    logic [3:0] r;
    s = 7'd0;
    for (int i = 0; i < 8; i++) begin
      s = s + 7'(x[4*i +: 4]);
    end
    s2 = 5'(s[3:0]) + 5'(s[6:4]);
    s3 = 4'(5'(s2[3:0]) + 5'(s2[4]));
    r  = s3;
    if (r >= 4'd12)     r = r - 4'd12;
    else if (r >= 4'd6) r = r - 4'd6;
    if (r >= 4'd3)      r = r - 4'd3;
    return r[1:0];
  endfunction

  // Combine residues mod 2 and mod 3 into a residue mod 6
  function automatic logic [2:0] mod6_32(input logic [31:0] x);
    logic [1:0] r3;
    r3 = mod3_32(x);
    return (r3[0] != x[0]) ? 3'(r3) + 3'd3 : 3'(r3);
  endfunction

  // 32-bit value mod 25: 256 == 6 (mod 25), fold bytes then reciprocal estimate
  function automatic logic [4:0] mod25_32(input logic [31:0] x);
    logic [13:0] t;
    logic [8:0]  u;
    logic [8:0]  v;
    logic [14:0] qp;
    logic [4:0]  q;
    logic [8:0]  r;
    t  = 14'(x[7:0]) + 14'(x[15:8]) * 14'd6 + 14'(x[23:16]) * 14'd11
         + 14'(x[31:24]) * 14'd16;
    u  = 9'(t[7:0]) + 9'(t[13:8]) * 9'd6;
    v  = 9'(u[7:0]) + (u[8] ? 9'd6 : 9'd0);
    // 41/1024 is close enough to 1/25 for v below 262
    qp = 15'(v) * 15'd41;
    q  = qp[14:10];
    r  = v - 9'(q) * 9'd25;
    return r[4:0];
  endfunction

endpackage

FILE: design/archive_byte_descrambler.sv
// Channel  | Signals                          | Transfer when
// ---------+----------------------------------+---------------------------
// input    | in_valid, in_ready, in_data      | in_valid && in_ready
// result   | out_valid, out_ready, out_data   | out_valid && out_ready
// config   | cfg_we, cfg_index, cfg_wdata     | cfg_we
//
// One byte per cycle sustained while the result side does not stall; input register then
// result register, with the descramble logic between them.
// Offset residues are worked out when start_offset is written.
// Reset (rst_n low, synchronous) clears control and config registers, mode to pass-through.
// A stall on the result side holds both stages; ready stays combinational.
module archive_byte_descrambler
  import abd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  abd_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output abd_out_t    out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);

`include "archive_byte_descrambler_assert.svh"

  // Configuration, kept as residues of the offset
  logic       bypass_r;
  logic       off_nz_r;
  logic [1:0] cfg_m4_r;
  logic [1:0] cfg_m3_r;
  logic [2:0] cfg_m6_r;
  logic [4:0] cfg_m25_r;

  // Resource state
  logic [1:0] mode_r, mode_nxt;
  logic [1:0] pos4_r, pos4_nxt;
  logic [1:0] pos3_r, pos3_nxt;
  logic [2:0] pos6_r, pos6_nxt;
  logic [4:0] pos25_r, pos25_nxt;
  logic [2:0] off6_r, off6_nxt;

  // Pipeline registers
  logic     s1_valid_r;
  abd_in_t  s1_data_r;
  logic     out_valid_r;
  abd_out_t out_data_r, out_data_nxt;

  logic s2_ready;
  logic s1_adv;

  // Handshake
  assign s2_ready  = !out_valid_r || out_ready;
  assign s1_adv    = s1_valid_r && s2_ready;
  assign in_ready  = !s1_valid_r || s2_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bypass_r  <= 1'b0;
      off_nz_r  <= 1'b0;
      cfg_m4_r  <= 2'd0;
      cfg_m3_r  <= 2'd0;
      cfg_m6_r  <= 3'd0;
      cfg_m25_r <= 5'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BYPASS_PLAIN: bypass_r <= cfg_wdata[0];
        CFG_START_OFFSET: begin
          off_nz_r  <= (cfg_wdata != 32'd0);
          cfg_m4_r  <= cfg_wdata[1:0];
          cfg_m3_r  <= mod3_32(cfg_wdata);
          cfg_m6_r  <= mod6_32(cfg_wdata);
          cfg_m25_r <= mod25_32(cfg_wdata);
        end
        default: ;
      endcase
    end
  end

  // Descramble one byte from the input register
  always_comb begin
    logic [1:0] mode_e;
    logic [1:0] p4, p3, o3;
    logic [2:0] p6, o6, swap_pos;
    logic [4:0] p25;
    logic       neg_en, xor_en, swap_en;
    logic [7:0] key, b0, a1, a2, a3, c1, c2, c3, res;

    // Restart position and mode on the first byte
    if (s1_data_r.first_byte) begin
      if (off_nz_r || s1_data_r.data_byte[7]) mode_e = MODE_A;
      else if (bypass_r)                      mode_e = MODE_PASS;
      else                                    mode_e = MODE_B;
      p4  = cfg_m4_r;
      p3  = cfg_m3_r;
      p6  = cfg_m6_r;
      p25 = cfg_m25_r;
      o6  = cfg_m6_r;
    end else begin
      mode_e = mode_r;
      p4  = pos4_r;
      p3  = pos3_r;
      p6  = pos6_r;
      p25 = pos25_r;
      o6  = off6_r;
    end

    o3       = (o6 >= 3'd3) ? 2'(o6 - 3'd3) : o6[1:0];
    swap_pos = (o6 >= 3'd4) ? o6 - 3'd4 : o6 + 3'd2;
    neg_en   = (p4 == 2'd1);
    xor_en   = (p3 == o3);
    swap_en  = (p6 == swap_pos);
    key      = xor_key(4'(div5(p25)) + 4'(p6));

    b0 = s1_data_r.data_byte;
    // Order A: negate, xor, swap
    a1 = neg_en  ? 8'(8'd0 - b0) : b0;
    a2 = xor_en  ? a1 ^ key : a1;
    a3 = swap_en ? {a2[3:0], a2[7:4]} : a2;
    // Order B: swap, xor, negate
    c1 = swap_en ? {b0[3:0], b0[7:4]} : b0;
    c2 = xor_en  ? c1 ^ key : c1;
    c3 = neg_en  ? 8'(8'd0 - c2) : c2;

    case (mode_e)
      MODE_A:  res = a3;
      MODE_B:  res = c3;
      default: res = b0;
    endcase

    out_data_nxt.plain_byte = res;
    out_data_nxt.last_out   = s1_data_r.last_byte;

    // Position steps on by one
    mode_nxt  = mode_e;
    off6_nxt  = o6;
    pos4_nxt  = p4 + 2'd1;
    pos3_nxt  = (p3 == 2'd2) ? 2'd0 : p3 + 2'd1;
    pos6_nxt  = (p6 == 3'd5) ? 3'd0 : p6 + 3'd1;
    pos25_nxt = (p25 == 5'd24) ? 5'd0 : p25 + 5'd1;
  end

  // Control and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      mode_r      <= MODE_PASS;
      pos4_r      <= 2'd0;
      pos3_r      <= 2'd0;
      pos6_r      <= 3'd0;
      pos25_r     <= 5'd0;
      off6_r      <= 3'd0;
    end else begin
      if (in_ready) s1_valid_r <= in_valid;
      if (s2_ready) out_valid_r <= s1_valid_r;
      if (s1_adv) begin
        mode_r  <= mode_nxt;
        pos4_r  <= pos4_nxt;
        pos3_r  <= pos3_nxt;
        pos6_r  <= pos6_nxt;
        pos25_r <= pos25_nxt;
        off6_r  <= off6_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_data_r <= in_data;
    if (s1_adv)               out_data_r <= out_data_nxt;
  end

  // Checks
  `ABD_ASSERT_ALWAYS(a_pos_range, clk, rst_n, (pos3_r != 2'd3) && (pos6_r <= 3'd5) && (pos25_r <= 5'd24) && (off6_r <= 3'd5))
  `ABD_ASSERT_ALWAYS(a_cfg_range, clk, rst_n, (cfg_m3_r != 2'd3) && (cfg_m6_r <= 3'd5) && (cfg_m25_r <= 5'd24) && (cfg_m6_r[0] == cfg_m4_r[0]))
  `ABD_ASSERT_NEXT(a_adv_out, clk, rst_n, s1_adv, out_valid_r)
  `ABD_ASSERT_NEXT(a_pos4_step, clk, rst_n, s1_adv && !s1_data_r.first_byte, pos4_r == 2'($past(pos4_r) + 2'd1))

endmodule

FILE: tb/sv/descrambler_checker.sv
module descrambler_checker
  import abd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  abd_in_t     in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  abd_out_t    out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  output int          n_failed,
  output int          n_due
);
  timeunit 1ns;
  timeprecision 1ps;

  // XOR keys, entry 0 in the low byte
  localparam logic [79:0] XOR_KEYS = {8'hff, 8'h30, 8'h00, 8'ha5, 8'haa,
                                      8'h9c, 8'h01, 8'hff, 8'hff, 8'hff};

  // Shadow of the registers as written
  logic        bypass_q;
  logic [31:0] offset_q;

  // Resource state, latched at the first byte
  logic [1:0] mode_q;
  logic [1:0] pos4_q;
  logic [1:0] pos3_q;
  logic [2:0] pos6_q;
  logic [4:0] pos25_q;
  logic [2:0] off6_q;

  abd_out_t plain_due [$];

  // Descramble one byte at the current position
  function automatic logic [7:0] unscramble(input logic [7:0] raw);
    logic [7:0] b;
    logic [7:0] key;
    logic       do_neg;
    logic       do_xor;
    logic       do_swap;
    b       = raw;
    key     = XOR_KEYS[8 * (int'(pos25_q / 5) + int'(pos6_q)) +: 8];
    do_neg  = (pos4_q == 2'd1);
    do_xor  = (int'(pos3_q) == int'(off6_q) % 3);
    do_swap = (int'(pos6_q) == (int'(off6_q) + 2) % 6);
    case (mode_q)
      MODE_A: begin
        if (do_neg) b = 8'd0 - b;
        if (do_xor) b = b ^ key;
        if (do_swap) b = {b[3:0], b[7:4]};
      end
      MODE_B: begin
        if (do_swap) b = {b[3:0], b[7:4]};
        if (do_xor) b = b ^ key;
        if (do_neg) b = 8'd0 - b;
      end
      default: ;
    endcase
    return b;
  endfunction

  always @(posedge clk) begin
    abd_out_t due;
    abd_out_t got;
    if (!rst_n) begin
      bypass_q = 1'b0;
      offset_q = '0;
      mode_q   = MODE_PASS;
      pos4_q   = '0;
      pos3_q   = '0;
      pos6_q   = '0;
      pos25_q  = '0;
      off6_q   = '0;
      plain_due.delete();
      n_failed = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BYPASS_PLAIN: bypass_q = cfg_wdata[0];
          CFG_START_OFFSET: offset_q = cfg_wdata;
          default: ;
        endcase
      end

      // Result transfer: compare with the oldest expectation
      if (out_valid && out_ready) begin
        got = out_data;
        if (plain_due.size() == 0) begin
          $error("unexpected result: plain_byte %h last_out %b", got.plain_byte, got.last_out);
          n_failed++;
        end else begin
          due = plain_due.pop_front();
          if (got.plain_byte !== due.plain_byte) begin
            $error("plain_byte: expected %h, got %h", due.plain_byte, got.plain_byte);
            n_failed++;
          end
          if (got.last_out !== due.last_out) begin
            $error("last_out: expected %b, got %b", due.last_out, got.last_out);
            n_failed++;
          end
        end
      end

      // Input transfer: a first byte picks the mode and restarts the position
      if (in_valid && in_ready) begin
        if (in_data.first_byte) begin
          if (offset_q != 0 || in_data.data_byte[7]) mode_q = MODE_A;
          else if (bypass_q) mode_q = MODE_PASS;
          else mode_q = MODE_B;
          pos4_q  = 2'(offset_q % 4);
          pos3_q  = 2'(offset_q % 3);
          pos6_q  = 3'(offset_q % 6);
          pos25_q = 5'(offset_q % 25);
          off6_q  = 3'(offset_q % 6);
        end
        due.plain_byte = unscramble(in_data.data_byte);
        due.last_out   = in_data.last_byte;
        plain_due.push_back(due);
        // position is unbounded, so only the residues move on
        pos4_q  = pos4_q + 2'd1;
        pos3_q  = (pos3_q == 2'd2) ? 2'd0 : pos3_q + 2'd1;
        pos6_q  = (pos6_q == 3'd5) ? 3'd0 : pos6_q + 3'd1;
        pos25_q = (pos25_q == 5'd24) ? 5'd0 : pos25_q + 5'd1;
      end
    end
    n_due = plain_due.size();
  end

endmodule

FILE: tb/sv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import abd_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  abd_in_t     in_data;
  logic        out_valid;
  logic        out_ready;
  abd_out_t    out_data;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_wdata;
  int          n_failed;
  int          n_due;

  int tx_idle_pct = 32;
  int rx_idle_pct = 60;
  int hold_req = 0;

  archive_byte_descrambler uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  descrambler_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .n_failed  (n_failed),
    .n_due     (n_due)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard limit on run length
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver: random stalls, or a long hold-off counted down here
  initial begin
    int hold_done;
    int rx_hold;
    hold_done = 0;
    rx_hold   = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_done) begin
        hold_done = hold_req;
        rx_hold   = 400;
      end
      if (rx_hold > 0) begin
        out_ready = 1'b0;
        rx_hold--;
      end else begin
        out_ready = ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Offer one byte, with random gaps, and wait for its transfer
  task automatic put_byte(input logic [7:0] d, input logic f, input logic l);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid             = 1'b1;
    in_data.data_byte    = d;
    in_data.first_byte   = f;
    in_data.last_byte    = l;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] v);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // Drain every outstanding byte, then wait out the tail for the pipeline
  task automatic settle(input int tail);
    in_valid = 1'b0;
    while (n_due != 0) @(negedge clk);
    repeat (tail) @(negedge clk);
  endtask

  task automatic set_config(input logic bypass, input logic [31:0] offset);
    settle(4);
    write_reg(CFG_BYPASS_PLAIN, {31'd0, bypass});
    write_reg(CFG_START_OFFSET, offset);
  endtask

  // Mostly whole resources; now and then random flags
  task automatic send_stream(input int n);
    int   sent;
    int   len;
    logic broken;
    logic f;
    logic l;
    sent = 0;
    while (sent < n) begin
      len    = ($urandom_range(7) == 0) ? 1 : $urandom_range(40, 2);
      broken = ($urandom_range(9) == 0);
      for (int k = 0; k < len; k++) begin
        if (broken) begin
          f = 1'($urandom);
          l = 1'($urandom);
        end else begin
          f = (k == 0);
          l = (k == len - 1);
        end
        put_byte(8'($urandom), f, l);
      end
      sent += len;
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_BYPASS_PLAIN;
    cfg_wdata = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Bytes ahead of any first byte pass unchanged, counters still run
    put_byte(8'ha5, 1'b0, 1'b0);
    put_byte(8'h00, 1'b0, 1'b1);

    // Mode B: offset zero, bit 7 clear, no bypass; data extremes
    set_config(1'b0, 32'd0);
    put_byte(8'h00, 1'b1, 1'b0);
    put_byte(8'hff, 1'b0, 1'b0);
    put_byte(8'h80, 1'b0, 1'b0);
    put_byte(8'h7f, 1'b0, 1'b0);
    put_byte(8'h01, 1'b0, 1'b0);
    put_byte(8'h10, 1'b0, 1'b1);

    // Mode A from bit 7, then bytes past the last one keep counting
    put_byte(8'h80, 1'b1, 1'b0);
    put_byte(8'h3c, 1'b0, 1'b0);
    put_byte(8'hff, 1'b0, 1'b1);
    put_byte(8'h55, 1'b0, 1'b0);
    put_byte(8'haa, 1'b0, 1'b0);

    // Writes inside a resource only count from the next first byte
    set_config(1'b1, 32'd5);
    put_byte(8'h12, 1'b0, 1'b0);
    put_byte(8'h34, 1'b0, 1'b1);
    put_byte(8'h05, 1'b1, 1'b0);
    put_byte(8'hf0, 1'b0, 1'b1);

    // Bypass with a plain first byte
    set_config(1'b1, 32'd0);
    put_byte(8'h05, 1'b1, 1'b0);
    put_byte(8'hf0, 1'b0, 1'b1);

    // Largest offset: position runs past 32 bits
    set_config(1'b0, 32'hffff_ffff);
    put_byte(8'h00, 1'b1, 1'b0);
    for (int k = 0; k < 4; k++) put_byte(8'($urandom), 1'b0, 1'b0);
    put_byte(8'($urandom), 1'b0, 1'b1);

    // Random part over three stall regimes
    for (int r = 0; r < 3; r++) begin
      case (r)
        0: begin
          tx_idle_pct = 32;
          rx_idle_pct = 60;
        end
        1: begin
          tx_idle_pct = 60;
          rx_idle_pct = 32;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (int ph = 0; ph < 4; ph++) begin
        case (ph)
          0: set_config(1'b0, 32'd0);
          1: set_config(1'b1, 32'd0);
          2: set_config(1'($urandom), 32'hffff_ffff - $urandom_range(48));
          default: set_config(1'($urandom),
                              $urandom_range(1) ? $urandom : $urandom_range(30, 1));
        endcase
        // long receiver hold-off so the block backs up onto its input
        if (r == 2 && ph == 1) hold_req++;
        send_stream(115);
      end
    end

    settle(10);
    if (n_failed == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: archive_byte_descrambler.f
+incdir+design
design/abd_pkg.sv
design/archive_byte_descrambler.sv
tb/sv/descrambler_checker.sv
tb/sv/testbench.sv
